FILE: rtl/core/command_line_tokenizer_defines.svh
// Assertion macros for the checker file of the command line tokenizer.
// Each macro places one labeled concurrent assertion clocked on the rising edge
// and disabled while the active-low reset is asserted.
`ifndef COMMAND_LINE_TOKENIZER_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define CLT_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define CLT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

FILE: rtl/core/clt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Shared types, token kind codes, scan modes and character constants.
// ----------------------------------------------------------------------------
package clt_pkg;

    // Default line length; positions saturate at one below it.
    localparam int LINE_MAX_DEF = 128;

    // Width of the reported positions and of a number value.
    localparam int POS_OUT_W = 7;
    localparam int VALUE_W   = 32;

    // Character codes the scanner reacts to.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_Z      = 8'h7A;

    // Token kinds as reported on the result channel.
    typedef enum logic [3:0] {
        KIND_NAME     = 4'd0,
        KIND_NUMBER   = 4'd1,
        KIND_STRING   = 4'd2,
        KIND_OPERATOR = 4'd3,
        KIND_COMMA    = 4'd4,
        KIND_LINE_END = 4'd5,
        KIND_ERROR    = 4'd6,
        KIND_OPEN     = 4'd7,
        KIND_CLOSE    = 4'd8
    } kind_t;

    // Scan modes between input bytes.
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_ZERO = 3'd1,
        MODE_DEC  = 3'd2,
        MODE_HEX  = 3'd3,
        MODE_NAME = 3'd4,
        MODE_STR  = 3'd5
    } mode_t;

    // One token as it leaves the block.
    typedef struct packed {
        kind_t                  kind;
        logic [VALUE_W-1:0]     value;
        logic [POS_OUT_W-1:0]   spos;
        logic [POS_OUT_W-1:0]   epos;
    } tok_t;

    // Tokens produced by one input byte, in order, with their count.
    typedef struct packed {
        tok_t       tok0;
        tok_t       tok1;
        logic [1:0] count;
    } res_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CH_A) && (c <= CH_Z);
    endfunction

    function automatic logic is_hexdigit(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_A) && (c <= CH_F));
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    endfunction

endpackage

FILE: rtl/core/clt_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer scanner
// Holds the scan state and turns one byte into up to two tokens per step.
// ----------------------------------------------------------------------------
module clt_scanner
    import clt_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] char_in,
    output res_t       res
);

    localparam int POS_W = $clog2(LINE_MAX);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_MAX - 1);

    mode_t              mode_reg, mode_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    logic [POS_W+POS_OUT_W-1:0] pos_ext;
    logic [POS_W+POS_OUT_W-1:0] start_ext;
    logic [POS_OUT_W-1:0]       p7;
    logic [POS_OUT_W-1:0]       s7;
    logic [3:0]                 dig;
    logic [3:0]                 hex_dig;
    logic [VALUE_W-1:0]         acc_dec;
    logic [VALUE_W-1:0]         acc_hex;
    logic                       fresh;
    logic                       pend_vld;
    logic                       sec_vld;
    tok_t                       pend_tok;
    tok_t                       sec_tok;

    // Positions are reported in their low seven bits.
    assign pos_ext   = {{POS_OUT_W{1'b0}}, pos_reg};
    assign start_ext = {{POS_OUT_W{1'b0}}, start_reg};
    assign p7        = pos_ext[POS_OUT_W-1:0];
    assign s7        = start_ext[POS_OUT_W-1:0];

    // Digit values; a-f have low nibbles 1..6, so adding nine gives 10..15.
    assign dig     = char_in[3:0];
    assign hex_dig = is_digit(char_in) ? char_in[3:0] : (char_in[3:0] + 4'd9);

    // Accumulate by ten as shift-and-add, by sixteen as a shift.
    assign acc_dec = {acc_reg[VALUE_W-4:0], 3'b000} + {acc_reg[VALUE_W-2:0], 1'b0}
                   + VALUE_W'(dig);
    assign acc_hex = {acc_reg[VALUE_W-5:0], 4'b0000} + VALUE_W'(hex_dig);

    // Next state and tokens for the byte at hand.
    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        fresh      = 1'b0;
        pend_vld   = 1'b0;
        sec_vld    = 1'b0;
        pend_tok   = '{kind: KIND_NUMBER, value: acc_reg, spos: s7, epos: p7};
        sec_tok    = '{kind: KIND_ERROR, value: '0, spos: p7, epos: p7};

        // Continue or close the pending token.
        unique case (mode_reg)
            MODE_ZERO:
            begin
                if (char_in == CH_X) begin
                    mode_next = MODE_HEX;
                end else if (is_digit(char_in)) begin
                    acc_next  = acc_dec;
                    mode_next = MODE_DEC;
                end else begin
                    pend_vld = 1'b1;
                    fresh    = 1'b1;
                end
            end
            MODE_DEC:
            begin
                if (is_digit(char_in)) begin
                    acc_next = acc_dec;
                end else begin
                    pend_vld = 1'b1;
                    fresh    = 1'b1;
                end
            end
            MODE_HEX:
            begin
                if (is_hexdigit(char_in)) begin
                    acc_next = acc_hex;
                end else begin
                    pend_vld = 1'b1;
                    fresh    = 1'b1;
                end
            end
            MODE_NAME:
            begin
                if (!(is_lower(char_in) || char_in == CH_COLON)) begin
                    pend_vld = 1'b1;
                    pend_tok = '{kind: KIND_NAME, value: '0, spos: s7, epos: p7};
                    fresh    = 1'b1;
                end
            end
            MODE_STR:
            begin
                if (char_in == CH_QUOTE) begin
                    pend_vld  = 1'b1;
                    pend_tok  = '{kind: KIND_STRING, value: '0, spos: s7, epos: p7};
                    mode_next = MODE_IDLE;
                end else if (char_in == CH_NUL) begin
                    // An unfinished string is an error, then the line ends.
                    pend_vld  = 1'b1;
                    pend_tok  = '{kind: KIND_ERROR, value: '0, spos: s7, epos: p7};
                    sec_vld   = 1'b1;
                    sec_tok   = '{kind: KIND_LINE_END, value: '0, spos: p7, epos: p7};
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase

        // Treat the byte as the start of something new.
        if (fresh) begin
            mode_next = MODE_IDLE;
            acc_next  = '0;
            if (is_digit(char_in)) begin
                start_next = pos_reg;
                acc_next   = VALUE_W'(dig);
                mode_next  = (char_in == CH_ZERO) ? MODE_ZERO : MODE_DEC;
            end else if (is_lower(char_in)) begin
                start_next = pos_reg;
                mode_next  = MODE_NAME;
            end else if (char_in == CH_QUOTE) begin
                start_next = pos_reg;
                mode_next  = MODE_STR;
            end else if (char_in == CH_SPACE) begin
                sec_vld = 1'b0;
            end else if (is_operator(char_in)) begin
                sec_vld = 1'b1;
                sec_tok = '{kind: KIND_OPERATOR, value: VALUE_W'(char_in), spos: p7, epos: p7};
            end else if (char_in == CH_NUL) begin
                sec_vld = 1'b1;
                sec_tok = '{kind: KIND_LINE_END, value: '0, spos: p7, epos: p7};
            end else if (char_in == CH_LBRACK) begin
                sec_vld = 1'b1;
                sec_tok = '{kind: KIND_OPEN, value: '0, spos: p7, epos: p7};
            end else if (char_in == CH_RBRACK) begin
                sec_vld = 1'b1;
                sec_tok = '{kind: KIND_CLOSE, value: '0, spos: p7, epos: p7};
            end else if (char_in == CH_COMMA) begin
                sec_vld = 1'b1;
                sec_tok = '{kind: KIND_COMMA, value: '0, spos: p7, epos: p7};
            end else begin
                sec_vld = 1'b1;
            end
        end

        // Line end clears everything; otherwise the position saturates.
        if (char_in == CH_NUL) begin
            pos_next   = '0;
            mode_next  = MODE_IDLE;
            acc_next   = '0;
            start_next = '0;
        end else if (pos_reg != POS_LAST) begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // Tokens in emission order.
    assign res.tok0  = pend_vld ? pend_tok : sec_tok;
    assign res.tok1  = sec_tok;
    assign res.count = {1'b0, pend_vld} + {1'b0, sec_vld};

    // Scan state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            acc_reg   <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

FILE: rtl/core/clt_result_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer result buffer
// Two token slots loaded together and drained one item per handshake.
// ----------------------------------------------------------------------------
module clt_result_buf
    import clt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  res_t res,
    input  logic out_ready,
    output logic free,
    output logic out_valid,
    output tok_t out_tok,
    output logic out_last
);

    logic [1:0] cnt_reg;
    tok_t       slot0_reg;
    tok_t       slot1_reg;
    logic       pop;

    // The buffer can take a new pair when it will be empty after this cycle.
    assign free      = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_tok   = slot0_reg;
    assign out_last  = (cnt_reg == 2'd1);
    assign pop       = out_valid && out_ready;

    // Token count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= res.count;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Token slots; the second moves up when the first is taken.
    always_ff @(posedge clk)
    begin
        if (load) begin
            slot0_reg <= res.tok0;
            slot1_reg <= res.tok1;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

FILE: rtl/core/command_line_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer
// Scans a command line one byte per item and emits its tokens.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   character
//   result    out_valid / out_ready token_kind, token_value, start_pos,
//                                   end_pos, last_of_run
//
// One byte is scanned per cycle: it waits in the input register and is
// processed in the cycle the two-slot result buffer can take its tokens.
// A byte yielding two tokens holds the scanner while both are in the buffer.
// An accepted byte passes the input register, then the result buffer.
// Reset clears the scan state, the position and both valid flags.
// A stalled result side still lets one more byte be accepted.
// ----------------------------------------------------------------------------
module command_line_tokenizer
    import clt_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  character,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [31:0] token_value,
    output logic [6:0]  start_pos,
    output logic [6:0]  end_pos,
    output logic        last_of_run
);

    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       free;
    logic       step;
    res_t       res;
    tok_t       out_tok;

    // A buffered byte advances when the result buffer has room.
    assign step     = in_valid_reg && free;
    assign in_ready = !in_valid_reg || free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            char_reg <= character;
        end
    end

    clt_scanner #(
        .LINE_MAX (LINE_MAX)
    ) u_scanner (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .char_in (char_reg),
        .res     (res)
    );

    clt_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res       (res),
        .out_ready (out_ready),
        .free      (free),
        .out_valid (out_valid),
        .out_tok   (out_tok),
        .out_last  (last_of_run)
    );

    // Result fields.
    assign token_kind  = out_tok.kind;
    assign token_value = out_tok.value;
    assign start_pos   = out_tok.spos;
    assign end_pos     = out_tok.epos;

endmodule

FILE: rtl/core/clt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Watches the result channel of the tokenizer and is bound to its top level.
// ----------------------------------------------------------------------------
`include "command_line_tokenizer_defines.svh"

module clt_checker
    import clt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  token_kind,
    input logic [31:0] token_value,
    input logic [6:0]  start_pos,
    input logic [6:0]  end_pos,
    input logic        last_of_run
);

    logic valueless;

    // Only numbers and operators carry a value.
    assign valueless = (token_kind != KIND_NUMBER) && (token_kind != KIND_OPERATOR);

    // A stalled result holds its value.
    `CLT_ASSERT_NEXT(a_hold_value, clk, rst_n, out_valid && !out_ready, out_valid && $stable(token_value))

    // A token that is not the last of its byte is followed at once by another.
    `CLT_ASSERT_NEXT(a_run_continues, clk, rst_n, out_valid && out_ready && !last_of_run, out_valid)

    // Kinds without a value report zero.
    `CLT_ASSERT_IMPLY(a_zero_value, clk, rst_n, out_valid && valueless, token_value == 32'd0)

    // A line end is a one-byte token and always closes its byte's run.
    `CLT_ASSERT_IMPLY(a_line_end, clk, rst_n, out_valid && token_kind == KIND_LINE_END, start_pos == end_pos && last_of_run)

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .token_kind  (token_kind),
    .token_value (token_value),
    .start_pos   (start_pos),
    .end_pos     (end_pos),
    .last_of_run (last_of_run)
);
